/* design/lkv_pkg.sv */
package lkv_pkg;

  localparam int CACHE_DEPTH = 16;
  localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [AGE_W-1:0] age_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [1:0] {
    RANK_NONE,
    RANK_PROMOTE,
    RANK_INSERT
  } rank_kind_t;

  typedef struct packed {
    rank_kind_t kind;
    idx_t       slot;
  } rank_op_t;

endpackage

/* design/lkv_if.sv */
interface lkv_req_if;
  logic          valid;
  logic          ready;
  logic          cmd;
  lkv_pkg::key_t key;
  lkv_pkg::val_t value;

  modport source (output valid, cmd, key, value, input ready);
  modport sink (input valid, cmd, key, value, output ready);
endinterface

interface lkv_rsp_if;
  logic          valid;
  logic          ready;
  logic          found;
  lkv_pkg::val_t read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink (input valid, found, read_value, output ready);
endinterface

interface lkv_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lkv_pkg::CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* design/lkv_store.sv */
module lkv_store (
  input  logic          clk,
  input  logic          rd_en,
  input  lkv_pkg::idx_t rd_addr,
  output lkv_pkg::key_t rd_key,
  output lkv_pkg::val_t rd_value,
  input  logic          wr_en,
  input  lkv_pkg::idx_t wr_addr,
  input  lkv_pkg::key_t wr_key,
  input  lkv_pkg::val_t wr_value
);
  import lkv_pkg::*;

  key_t key_mem [CACHE_DEPTH];
  val_t val_mem [CACHE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_value;
    end
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= val_mem[rd_addr];
    end
  end

endmodule

/* design/lkv_rank.sv */
module lkv_rank (
  input  logic              clk,
  input  logic              rst,
  input  lkv_pkg::idx_t     q_idx,
  output logic              q_valid,
  output lkv_pkg::age_t     q_age,
  output lkv_pkg::cnt_t     used,
  input  lkv_pkg::rank_op_t op
);
  import lkv_pkg::*;

  logic [CACHE_DEPTH-1:0] valid;
  age_t                   age [CACHE_DEPTH];

  assign q_valid = valid[q_idx];
  assign q_age   = age[q_idx];

  // Age 0 is the most recent entry; valid ages always form the ranks 0 to used-1.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      used  <= '0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        age[i] <= '0;
      end
    end else begin
      case (op.kind)
        RANK_PROMOTE: begin
          for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (valid[i] && age[i] < age[op.slot]) begin
              age[i] <= age[i] + AGE_W'(1);
            end
          end
          age[op.slot] <= '0;
        end
        RANK_INSERT: begin
          for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (valid[i]) begin
              age[i] <= age[i] + AGE_W'(1);
            end
          end
          valid[op.slot] <= 1'b1;
          age[op.slot]   <= '0;
          used           <= used + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(CACHE_DEPTH))
    else $error("entry count exceeds the depth");

  a_used_matches: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(valid)) == used)
    else $error("entry count disagrees with the valid bits");

  a_promote_zero: assert property (@(posedge clk) disable iff (rst)
    (op.kind == RANK_PROMOTE || op.kind == RANK_INSERT) |=>
      (age[$past(op.slot)] == '0 && valid[$past(op.slot)]))
    else $error("touched entry is not the most recent");

endmodule

/* design/lru_key_value_cache.sv */
// Fully associative key-value cache of CACHE_DEPTH entries with least-recently-used
// replacement. Each request is a get or a put; every request yields exactly one response
// giving found and, for a get that hits, the stored value (0 otherwise). The block takes
// one request at a time; its occupancy is set by the key search, which reads one stored
// entry per cycle through a single memory read port and one shared key comparator,
// followed by an update state that updates the recency ranks and, for a put, writes the
// entry. The response is loaded into a free output register and waits there, so a
// slow consumer delays the next request only while that register is still full.
// capacity_in_use limits the number of entries held before eviction; 0 acts as 1 and
// values above the depth act as the depth. Lowering it never drops entries already held.
module lru_key_value_cache (
  input logic        clk,
  input logic        rst,
  lkv_req_if.sink    req,
  lkv_rsp_if.source  rsp,
  lkv_cfg_if.sink    cfg
);
  import lkv_pkg::*;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;
  localparam idx_t LAST_IDX = IDX_W'(CACHE_DEPTH - 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  state_t           state;
  logic [CAP_W-1:0] capacity_in_use;

  logic cmd_r;
  key_t key_r;
  val_t val_r;

  idx_t cnt;
  logic issuing;
  logic cmp_live;
  idx_t cmp_idx;

  logic hit;
  idx_t hit_idx;
  val_t hit_val;
  logic free_found;
  idx_t free_idx;
  logic vic_found;
  idx_t vic_idx;
  age_t vic_age;

  logic found_r;
  val_t rd_r;

  key_t     rd_key;
  val_t     rd_value;
  logic     q_valid;
  age_t     q_age;
  cnt_t     used;
  rank_op_t rank_op;
  logic     wr_en;
  idx_t     wr_addr;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic             room;
  logic             out_free;
  logic             rsp_load;
  val_t             rd_next;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free  = !rsp.valid || rsp.ready;
  assign rsp_load  = (state inside {ST_UPDATE, ST_RESP}) && out_free;
  assign rd_next   = (cmd_r == CMD_GET && hit) ? hit_val : '0;

  always_comb begin
    cap_ext = CMP_W'(capacity_in_use);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CACHE_DEPTH)) begin
      eff_cap = CMP_W'(CACHE_DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
    room = CMP_W'(used) < eff_cap;
  end

  // A put that misses fills a free slot while there is room, otherwise it takes over the
  // oldest entry, which then becomes the most recent.
  always_comb begin
    rank_op = '{kind: RANK_NONE, slot: hit_idx};
    wr_en   = 1'b0;
    wr_addr = hit_idx;
    if (state == ST_UPDATE) begin
      if (hit) begin
        rank_op = '{kind: RANK_PROMOTE, slot: hit_idx};
        wr_en   = (cmd_r == CMD_PUT);
      end else if (cmd_r == CMD_PUT) begin
        if (room) begin
          if (free_found) begin
            rank_op = '{kind: RANK_INSERT, slot: free_idx};
            wr_en   = 1'b1;
            wr_addr = free_idx;
          end
        end else if (vic_found) begin
          rank_op = '{kind: RANK_PROMOTE, slot: vic_idx};
          wr_en   = 1'b1;
          wr_addr = vic_idx;
        end
      end
    end
  end

  lkv_store u_store (
    .clk      (clk),
    .rd_en    (state == ST_SCAN && issuing),
    .rd_addr  (cnt),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (key_r),
    .wr_value (val_r)
  );

  lkv_rank u_rank (
    .clk     (clk),
    .rst     (rst),
    .q_idx   (cmp_idx),
    .q_valid (q_valid),
    .q_age   (q_age),
    .used    (used),
    .op      (rank_op)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity_in_use <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
      issuing   <= 1'b0;
      cmp_live  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd_r      <= req.cmd;
            key_r      <= req.key;
            val_r      <= req.value;
            cnt        <= '0;
            issuing    <= 1'b1;
            cmp_live   <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            vic_found  <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Read data arrives in the cycle after the address, so the compare trails the reads by one entry.
          cmp_live <= issuing;
          cmp_idx  <= cnt;
          if (issuing) begin
            if (cnt == LAST_IDX) begin
              issuing <= 1'b0;
            end else begin
              cnt <= cnt + IDX_W'(1);
            end
          end
          if (cmp_live) begin
            if (q_valid) begin
              if (!hit && rd_key == key_r) begin
                hit     <= 1'b1;
                hit_idx <= cmp_idx;
                hit_val <= rd_value;
              end
              if (!vic_found || q_age > vic_age) begin
                vic_found <= 1'b1;
                vic_idx   <= cmp_idx;
                vic_age   <= q_age;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
            if (cmp_idx == LAST_IDX) begin
              state <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          cmp_live <= 1'b0;
          found_r  <= hit;
          rd_r     <= rd_next;
          if (out_free) begin
            rsp.found      <= hit;
            rsp.read_value <= rd_next;
            state          <= ST_IDLE;
          end else begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            rsp.found      <= found_r;
            rsp.read_value <= rd_r;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && cmd_r == CMD_PUT && !hit && room) |-> free_found)
    else $error("insert with room but no free slot seen");

  a_victim: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && cmd_r == CMD_PUT && !hit && !room) |-> vic_found)
    else $error("full cache without a replacement candidate");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> rsp.read_value == '0)
    else $error("miss response carries a value");

endmodule
